// ----- sv/igv_pkg.sv -----
// Shared types, widths and status codes for the inverse Gaussian variate transform.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package igv_pkg;

    localparam int MU_W   = 32;
    localparam int NORM_W = 16;
    localparam int UNI_W  = 16;
    localparam int NORM_FRAC = 12;
    localparam int STAT_W = 2;
    localparam int MAG_W  = 16;
    localparam int Y_W    = 31;
    localparam int P_W    = 64;
    localparam int Z_W    = 38;
    localparam int W_W    = 39;
    localparam int T_W    = 40;
    localparam int ROOT_W = 39;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int D_W    = 41;
    localparam int Q1_W   = 31;
    localparam int ACC_W  = MU_W + 1 + UNI_W;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_MEAN = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID   = 2'd2;
    localparam logic [STAT_W-1:0] ST_SATURATED = 2'd3;

    typedef struct packed {
        logic [MU_W-1:0]   mu;
        logic [UNI_W-1:0]  u;
        logic              last;
        logic [STAT_W-1:0] stat;
    } igv_tag_t;

    typedef struct packed {
        igv_tag_t        tag;
        logic [T_W-1:0]  t;
        logic [P_W-1:0]  p;
    } igv_root_side_t;

    typedef struct packed {
        logic [STAT_W-1:0] stat;
        logic              last;
        logic              accept;
        logic              ovf;
        logic              x_zero;
        logic [MU_W-1:0]   x;
    } igv_fin_t;

    typedef struct packed {
        logic [MU_W-1:0]   variate;
        logic [STAT_W-1:0] status;
        logic              last;
    } igv_res_t;

endpackage

`default_nettype wire

// ----- sv/igv_sqrt.sv -----
// Pipelined floor square root, one result bit per register stage.
// Depends on nothing; the sideband is an opaque vector.
`timescale 1ns / 1ps
`default_nettype none

module igv_sqrt #(
    parameter int ROOT_W = 39,
    parameter int SIDE_W = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   radicand,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic              valid_reg [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [RAD_W-1:0]  rad_reg   [ROOT_W];
    logic [SIDE_W-1:0] side_reg  [ROOT_W];

    logic              src_valid [ROOT_W];
    logic [REM_W-1:0]  src_rem   [ROOT_W];
    logic [ROOT_W-1:0] src_root  [ROOT_W];
    logic [RAD_W-1:0]  src_rad   [ROOT_W];
    logic [SIDE_W-1:0] src_side  [ROOT_W];

    always_comb begin
        src_valid[0] = in_valid;
        src_rem[0]   = '0;
        src_root[0]  = '0;
        src_rad[0]   = radicand;
        src_side[0]  = in_side;
        for (int k = 1; k < ROOT_W; k++) begin
            src_valid[k] = valid_reg[k-1];
            src_rem[k]   = rem_reg[k-1];
            src_root[k]  = root_reg[k-1];
            src_rad[k]   = rad_reg[k-1];
            src_side[k]  = side_reg[k-1];
        end
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        logic              ge;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        // Bring down the next two radicand bits and try appending a one to the root.
        always_comb begin
            cur       = {src_rem[k], src_rad[k][RAD_W-1 -: 2]};
            trial     = (REM_W + 2)'({src_root[k], 2'b01});
            diff      = cur - trial;
            ge        = (cur >= trial);
            rem_next  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
            root_next = (src_root[k] << 1) | ROOT_W'(ge);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= src_valid[k];
            end
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= src_rad[k] << 2;
                side_reg[k] <= src_side[k];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ----- sv/igv_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// The dividend must be below divisor * 2**QUO_W; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

module igv_div #(
    parameter int DVD_W  = 64,
    parameter int DVS_W  = 41,
    parameter int QUO_W  = 31,
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quotient,
    output logic [DVS_W-1:0]  remainder,
    output logic [DVS_W-1:0]  out_divisor,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg [QUO_W];
    logic [DVS_W-1:0]  rem_reg   [QUO_W];
    logic [QUO_W-1:0]  low_reg   [QUO_W];
    logic [QUO_W-1:0]  quo_reg   [QUO_W];
    logic [DVS_W-1:0]  dvs_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];

    logic              src_valid [QUO_W];
    logic [DVS_W-1:0]  src_rem   [QUO_W];
    logic [QUO_W-1:0]  src_low   [QUO_W];
    logic [QUO_W-1:0]  src_quo   [QUO_W];
    logic [DVS_W-1:0]  src_dvs   [QUO_W];
    logic [SIDE_W-1:0] src_side  [QUO_W];

    always_comb begin
        src_valid[0] = in_valid;
        src_rem[0]   = DVS_W'(dividend >> QUO_W);
        src_low[0]   = dividend[QUO_W-1:0];
        src_quo[0]   = '0;
        src_dvs[0]   = divisor;
        src_side[0]  = in_side;
        for (int k = 1; k < QUO_W; k++) begin
            src_valid[k] = valid_reg[k-1];
            src_rem[k]   = rem_reg[k-1];
            src_low[k]   = low_reg[k-1];
            src_quo[k]   = quo_reg[k-1];
            src_dvs[k]   = dvs_reg[k-1];
            src_side[k]  = side_reg[k-1];
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DVS_W:0]   trial;
        logic [DVS_W:0]   diff;
        logic             ge;
        logic [DVS_W-1:0] rem_next;

        always_comb begin
            trial    = {src_rem[k], src_low[k][QUO_W-1]};
            diff     = trial - {1'b0, src_dvs[k]};
            ge       = (trial >= {1'b0, src_dvs[k]});
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= src_valid[k];
            end
            if (en) begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= src_low[k] << 1;
                quo_reg[k]  <= (src_quo[k] << 1) | QUO_W'(ge);
                dvs_reg[k]  <= src_dvs[k];
                side_reg[k] <= src_side[k];
            end
        end
    end

    assign out_valid   = valid_reg[QUO_W-1];
    assign quotient    = quo_reg[QUO_W-1];
    assign remainder   = rem_reg[QUO_W-1];
    assign out_divisor = dvs_reg[QUO_W-1];
    assign out_side    = side_reg[QUO_W-1];

endmodule

`default_nettype wire

// ----- sv/igv_out_buf.sv -----
// Two-entry output buffer that parts the pipeline from the result channel.
// Depends on igv_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module igv_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  igv_pkg::igv_res_t push_data,
    output logic              full,
    output logic              m_valid,
    input  logic              m_ready,
    output igv_pkg::igv_res_t m_data
);

    import igv_pkg::*;

    igv_res_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 2'd0);
    assign full    = (count_reg == 2'd2);
    assign m_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/inverse_gaussian_variate_transform.sv -----
// Inverse Gaussian variate transform, fixed-point pipeline of 112 register stages.
// It holds the 39-stage square root and the two dividers of 31 and 32 stages,
// one bit per stage. Throughput: one item per cycle; a two-entry output buffer
// holds the pipeline only when both entries wait. Reset clears all valid bits
// and the buffer. Depends on igv_pkg, igv_sqrt, igv_div and igv_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module inverse_gaussian_variate_transform (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_mean_value,
    input  logic [31:0] s_shape_value,
    input  logic signed [15:0] s_normal_sample,
    input  logic [15:0] s_uniform_sample,
    input  logic        s_last_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_variate,
    output logic [1:0]  m_status,
    output logic        m_last_out
);

    import igv_pkg::*;

    logic en;
    logic buf_full;

    assign en      = !buf_full;
    assign s_ready = en;

    // Stage 1: capture the item, fold the normal sample to its magnitude.
    logic             s1_v_reg;
    igv_tag_t         s1_tag_reg;
    logic [MU_W-1:0]  s1_lam_reg;
    logic [MAG_W-1:0] s1_mag_reg;
    igv_tag_t         s1_tag_next;
    logic [MAG_W-1:0] s1_mag_next;

    always_comb begin
        s1_tag_next.mu   = s_mean_value;
        s1_tag_next.u    = s_uniform_sample;
        s1_tag_next.last = s_last_in;
        if (s_mean_value == '0) begin
            s1_tag_next.stat = ST_ZERO_MEAN;
        end else if (s_shape_value == '0) begin
            s1_tag_next.stat = ST_INVALID;
        end else begin
            s1_tag_next.stat = ST_OK;
        end
        s1_mag_next = s_normal_sample[NORM_W-1] ? (~s_normal_sample + 16'd1) : s_normal_sample;
    end

    // Stage 2: y = n*n and p = mu*lambda.
    logic            s2_v_reg;
    igv_tag_t        s2_tag_reg;
    logic [MU_W-1:0] s2_lam_reg;
    logic [Y_W-1:0]  s2_y_reg;
    logic [P_W-1:0]  s2_p_reg;
    logic [2*MAG_W-1:0] s2_y_full;

    assign s2_y_full = s1_mag_reg * s1_mag_reg;

    // Stage 3: z = mu*y scaled back to the mean format.
    logic              s3_v_reg;
    igv_tag_t          s3_tag_reg;
    logic [MU_W-1:0]   s3_lam_reg;
    logic [P_W-1:0]    s3_p_reg;
    logic [Z_W-1:0]    s3_z_reg;
    logic [MU_W+Y_W-1:0] s3_zy;

    assign s3_zy = (MU_W + Y_W)'(s2_tag_reg.mu) * (MU_W + Y_W)'(s2_y_reg);

    // Stage 4: w = 4*lambda + z and t = 2*lambda + z.
    logic           s4_v_reg;
    igv_tag_t       s4_tag_reg;
    logic [P_W-1:0] s4_p_reg;
    logic [Z_W-1:0] s4_z_reg;
    logic [W_W-1:0] s4_w_reg;
    logic [T_W-1:0] s4_t_reg;

    // Stage 5: partial products of z*w.
    logic           s5_v_reg;
    igv_tag_t       s5_tag_reg;
    logic [P_W-1:0] s5_p_reg;
    logic [T_W-1:0] s5_t_reg;
    logic [63:0]    s5_ll_reg;
    logic [38:0]    s5_lh_reg;
    logic [37:0]    s5_hl_reg;
    logic [12:0]    s5_hh_reg;

    // Stage 6: the radicand z*w.
    logic           s6_v_reg;
    igv_root_side_t s6_side_reg;
    logic [RAD_W-1:0] s6_rad_reg;
    logic [RAD_W-1:0] s6_rad_next;

    always_comb begin
        s6_rad_next = RAD_W'(s5_ll_reg)
                    + ((RAD_W'(s5_lh_reg) + RAD_W'(s5_hl_reg)) << 32)
                    + (RAD_W'(s5_hh_reg) << 64);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg <= s_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
        end
        if (en) begin
            s1_tag_reg <= s1_tag_next;
            s1_lam_reg <= s_shape_value;
            s1_mag_reg <= s1_mag_next;

            s2_tag_reg <= s1_tag_reg;
            s2_lam_reg <= s1_lam_reg;
            s2_y_reg   <= s2_y_full[Y_W-1:0];
            s2_p_reg   <= P_W'(s1_tag_reg.mu) * P_W'(s1_lam_reg);

            s3_tag_reg <= s2_tag_reg;
            s3_lam_reg <= s2_lam_reg;
            s3_p_reg   <= s2_p_reg;
            s3_z_reg   <= Z_W'(s3_zy >> (2 * NORM_FRAC));

            s4_tag_reg <= s3_tag_reg;
            s4_p_reg   <= s3_p_reg;
            s4_z_reg   <= s3_z_reg;
            s4_w_reg   <= W_W'({s3_lam_reg, 2'b00}) + W_W'(s3_z_reg);
            s4_t_reg   <= T_W'({s3_lam_reg, 1'b0}) + T_W'(s3_z_reg);

            s5_tag_reg <= s4_tag_reg;
            s5_p_reg   <= s4_p_reg;
            s5_t_reg   <= s4_t_reg;
            s5_ll_reg  <= 64'(s4_z_reg[31:0]) * 64'(s4_w_reg[31:0]);
            s5_lh_reg  <= 39'(s4_z_reg[31:0]) * 39'(s4_w_reg[38:32]);
            s5_hl_reg  <= 38'(s4_z_reg[37:32]) * 38'(s4_w_reg[31:0]);
            s5_hh_reg  <= 13'(s4_z_reg[37:32]) * 13'(s4_w_reg[38:32]);

            s6_side_reg.tag <= s5_tag_reg;
            s6_side_reg.t   <= s5_t_reg;
            s6_side_reg.p   <= s5_p_reg;
            s6_rad_reg      <= s6_rad_next;
        end
    end

    // Square root of z*(4*lambda + z).
    logic           sq_v;
    logic [ROOT_W-1:0] sq_root;
    igv_root_side_t sq_side;

    igv_sqrt #(
        .ROOT_W (ROOT_W),
        .SIDE_W ($bits(igv_root_side_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s6_v_reg),
        .radicand  (s6_rad_reg),
        .in_side   (s6_side_reg),
        .out_valid (sq_v),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // Stage 7: denominator d = 2*lambda + z + b.
    logic           s7_v_reg;
    igv_tag_t       s7_tag_reg;
    logic [P_W-1:0] s7_p_reg;
    logic [D_W-1:0] s7_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_v_reg <= 1'b0;
        end else if (en) begin
            s7_v_reg <= sq_v;
        end
        if (en) begin
            s7_tag_reg <= sq_side.tag;
            s7_p_reg   <= sq_side.p;
            s7_d_reg   <= D_W'(sq_side.t) + D_W'(sq_root);
        end
    end

    // The quotient mu*lambda/d never exceeds mu/2, so 31 bits suffice.
    logic            dv1_v;
    logic [Q1_W-1:0] dv1_q;
    logic [D_W-1:0]  dv1_r;
    logic [D_W-1:0]  dv1_d;
    igv_tag_t        dv1_tag;

    igv_div #(
        .DVD_W  (P_W),
        .DVS_W  (D_W),
        .QUO_W  (Q1_W),
        .SIDE_W ($bits(igv_tag_t))
    ) u_div_root (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s7_v_reg),
        .dividend    (s7_p_reg),
        .divisor     (s7_d_reg),
        .in_side     (s7_tag_reg),
        .out_valid   (dv1_v),
        .quotient    (dv1_q),
        .remainder   (dv1_r),
        .out_divisor (dv1_d),
        .out_side    (dv1_tag)
    );

    // Stage 8: x = 2q rounded up when the remainder is at least half of d.
    logic            s8_v_reg;
    igv_tag_t        s8_tag_reg;
    logic [MU_W-1:0] s8_x_reg;
    logic            s8_round;

    assign s8_round = ({dv1_r, 1'b0} >= {1'b0, dv1_d});

    // Stage 9: accept test and mu*mu.
    logic             s9_v_reg;
    igv_fin_t         s9_fin_reg;
    logic [P_W-1:0]   s9_mm_reg;
    logic [ACC_W-1:0] s9_lhs;
    logic [ACC_W-1:0] s9_rhs;

    assign s9_lhs = ACC_W'(s8_tag_reg.u)
                  * ACC_W'(33'(s8_tag_reg.mu) + 33'(s8_x_reg));
    assign s9_rhs = ACC_W'({s8_tag_reg.mu, 16'h0000});

    // Stage 10: overflow check of mu*mu/x against 32 bits.
    logic           s10_v_reg;
    igv_fin_t       s10_fin_reg;
    igv_fin_t       s10_fin_next;
    logic [P_W-1:0] s10_mm_reg;

    always_comb begin
        s10_fin_next     = s9_fin_reg;
        s10_fin_next.ovf = (s9_mm_reg[P_W-1:MU_W] >= s9_fin_reg.x);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
        end else if (en) begin
            s8_v_reg  <= dv1_v;
            s9_v_reg  <= s8_v_reg;
            s10_v_reg <= s9_v_reg;
        end
        if (en) begin
            s8_tag_reg <= dv1_tag;
            s8_x_reg   <= {dv1_q, 1'b0} + MU_W'(s8_round);

            s9_fin_reg.stat   <= s8_tag_reg.stat;
            s9_fin_reg.last   <= s8_tag_reg.last;
            s9_fin_reg.accept <= (s9_lhs < s9_rhs);
            s9_fin_reg.ovf    <= 1'b0;
            s9_fin_reg.x_zero <= (s8_x_reg == '0);
            s9_fin_reg.x      <= s8_x_reg;
            s9_mm_reg         <= P_W'(s8_tag_reg.mu) * P_W'(s8_tag_reg.mu);

            s10_fin_reg <= s10_fin_next;
            s10_mm_reg  <= s9_mm_reg;
        end
    end

    // mu*mu/x; when it would overflow or x is zero the quotient is ignored.
    logic            dv2_v;
    logic [MU_W-1:0] dv2_q;
    igv_fin_t        dv2_fin;

    igv_div #(
        .DVD_W  (P_W),
        .DVS_W  (MU_W),
        .QUO_W  (MU_W),
        .SIDE_W ($bits(igv_fin_t))
    ) u_div_reject (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s10_v_reg),
        .dividend    (s10_mm_reg),
        .divisor     (s10_fin_reg.x),
        .in_side     (s10_fin_reg),
        .out_valid   (dv2_v),
        .quotient    (dv2_q),
        .remainder   (),
        .out_divisor (),
        .out_side    (dv2_fin)
    );

    igv_res_t res;

    always_comb begin
        res.last = dv2_fin.last;
        priority if (dv2_fin.stat != ST_OK) begin
            res.variate = '0;
            res.status  = dv2_fin.stat;
        end else if (dv2_fin.accept) begin
            res.variate = dv2_fin.x;
            res.status  = ST_OK;
        end else if (dv2_fin.x_zero) begin
            res.variate = '1;
            res.status  = ST_INVALID;
        end else if (dv2_fin.ovf) begin
            res.variate = '1;
            res.status  = ST_SATURATED;
        end else begin
            res.variate = dv2_q;
            res.status  = ST_OK;
        end
    end

    igv_res_t out_data;

    igv_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (dv2_v && en),
        .push_data (res),
        .full      (buf_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_data)
    );

    assign m_variate  = out_data.variate;
    assign m_status   = out_data.status;
    assign m_last_out = out_data.last;

endmodule

`default_nettype wire

// ----- sv/igv_checker.sv -----
// Port-level checks for the inverse Gaussian variate transform, bound to the top level.
// Depends on igv_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module igv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_variate,
    input logic [1:0]  m_status
);

    import igv_pkg::*;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_variate) && $stable(m_status))
        else $error("result changed while stalled");

    a_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_SATURATED |-> m_variate == 32'hFFFF_FFFF)
        else $error("saturated item without all-ones variate");

    a_zero_mean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_ZERO_MEAN |-> m_variate == 32'd0)
        else $error("zero-mean item with nonzero variate");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind inverse_gaussian_variate_transform igv_checker u_igv_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_variate (m_variate),
    .m_status  (m_status)
);

`default_nettype wire
